>>> sv/cfd_pkg.sv
// Shared constants, register codes and parser states of the frame deframer.
package cfd_pkg;

  localparam int PAYLOAD_BUFFER_BYTES = 64;
  localparam int STORE_ADDR_W = (PAYLOAD_BUFFER_BYTES > 1) ? $clog2(PAYLOAD_BUFFER_BYTES) : 1;
  localparam int BYTE_W = 8;
  localparam int INDEX_W = 6;
  localparam int COUNT_W = 7;
  localparam int LEN_OVERHEAD = 4;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_HEADER_FIRST = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HEADER_SECOND = 1'd1;

  typedef enum logic [2:0] {
    ST_HEAD1,
    ST_HEAD2,
    ST_LEN,
    ST_FUNC,
    ST_DATA,
    ST_EMIT_RD,
    ST_EMIT_WR,
    ST_EMPTY
  } phase_t;

endpackage

>>> sv/cfd_if.sv
// Stream and configuration channel interfaces of the frame deframer.
interface cfd_in_if;
  logic                      valid;
  logic                      ready;
  logic [cfd_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface cfd_out_if;
  logic                       valid;
  logic                       ready;
  logic [cfd_pkg::BYTE_W-1:0]  function_code;
  logic [cfd_pkg::BYTE_W-1:0]  payload_byte;
  logic [cfd_pkg::INDEX_W-1:0] byte_index;
  logic                       byte_present;
  logic                       last;

  modport source (output valid, output function_code, output payload_byte,
                  output byte_index, output byte_present, output last, input ready);
  modport sink (input valid, input function_code, input payload_byte,
                input byte_index, input byte_present, input last, output ready);
endinterface

interface cfd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [cfd_pkg::CFG_INDEX_W-1:0] index;
  logic [cfd_pkg::BYTE_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> sv/cfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/checksummed_frame_deframer_core.sv
// Top level of the checksummed frame deframer.
//
// Usage: received bytes enter on in_ch, one byte per transfer. The block
// hunts for the two header bytes held in the configuration registers, then
// takes a length byte, a function byte and length minus 4 data bytes, the
// last of which is an 8-bit sum checksum. Data bytes go to a payload RAM.
// A good frame leaves on out_ch as one transfer per payload byte, in order,
// with last set on the final one; a frame with only a checksum gives one
// transfer with byte_present low. Bad frames and bad lengths give nothing.
// Flow: in_ch is ready in every parsing state. After the checksum byte of
// a good frame, in_ch is held off while the payload is replayed from the
// RAM: each payload byte is a RAM read, then an output register load; a
// checksum-only frame needs only the load. The replay waits while the
// receiver stalls. The output register keeps its result while out_ch.ready
// is low; once the last transfer is loaded, parsing of new bytes continues.
// Reset: headers return to 0 and the hunt restarts at the first header.
// The RAM is not cleared; every entry read was written in the same frame.
// cfg accepts a write in every cycle.
module checksummed_frame_deframer_core (
  input logic     clk,
  input logic     rst,
  cfd_in_if.sink  in_ch,
  cfd_out_if.source out_ch,
  cfd_cfg_if.sink cfg
);

  cfd_pkg::phase_t state;
  cfd_pkg::phase_t state_next;

  logic [cfd_pkg::BYTE_W-1:0]  header_first;
  logic [cfd_pkg::BYTE_W-1:0]  header_second;
  logic [cfd_pkg::BYTE_W-1:0]  len_field;
  logic [cfd_pkg::BYTE_W-1:0]  frame_func;
  logic [cfd_pkg::COUNT_W-1:0] collect_count;
  logic [cfd_pkg::BYTE_W-1:0]  sum_acc;
  logic [cfd_pkg::INDEX_W-1:0] emit_idx;
  logic [cfd_pkg::INDEX_W-1:0] emit_end;

  logic                       out_valid;
  logic [cfd_pkg::BYTE_W-1:0]  out_func;
  logic [cfd_pkg::BYTE_W-1:0]  out_payload;
  logic [cfd_pkg::INDEX_W-1:0] out_index;
  logic                       out_present;
  logic                       out_last;

  logic                       in_ready;
  logic                       in_xfer;
  logic                       ram_we;
  logic                       ram_re;
  logic                       out_load;
  logic [cfd_pkg::BYTE_W-1:0]  ram_rdata;

  logic [cfd_pkg::BYTE_W-1:0]  data_len;
  logic                       len_bad;
  logic [cfd_pkg::COUNT_W-1:0] count_inc;
  logic                       frame_done;
  logic                       sum_ok;
  logic                       emit_last;

  assign in_xfer    = in_ch.valid && in_ready;
  assign data_len   = (len_field >= cfd_pkg::BYTE_W'(cfd_pkg::LEN_OVERHEAD)) ?
                      len_field - cfd_pkg::BYTE_W'(cfd_pkg::LEN_OVERHEAD) : '0;
  assign len_bad    = (data_len == '0) ||
                      (data_len > cfd_pkg::BYTE_W'(cfd_pkg::PAYLOAD_BUFFER_BYTES));
  assign count_inc  = collect_count + 1'b1;
  assign frame_done = ({1'b0, count_inc} == data_len);
  assign sum_ok     = (sum_acc + header_first + header_second) == in_ch.rx_byte;
  assign emit_last  = (emit_idx == emit_end);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      cfd_pkg::ST_HEAD1: begin
        if (in_xfer) begin
          state_next = (in_ch.rx_byte == header_first) ? cfd_pkg::ST_HEAD2 : cfd_pkg::ST_HEAD1;
        end
      end
      cfd_pkg::ST_HEAD2: begin
        if (in_xfer) begin
          state_next = (in_ch.rx_byte == header_second) ? cfd_pkg::ST_LEN : cfd_pkg::ST_HEAD1;
        end
      end
      cfd_pkg::ST_LEN: begin
        if (in_xfer) begin
          state_next = cfd_pkg::ST_FUNC;
        end
      end
      cfd_pkg::ST_FUNC: begin
        if (in_xfer) begin
          state_next = cfd_pkg::ST_DATA;
        end
      end
      cfd_pkg::ST_DATA: begin
        if (in_xfer) begin
          if (len_bad) begin
            state_next = cfd_pkg::ST_HEAD1;
          end else if (frame_done) begin
            if (!sum_ok) begin
              state_next = cfd_pkg::ST_HEAD1;
            end else if (data_len == cfd_pkg::BYTE_W'(1)) begin
              state_next = cfd_pkg::ST_EMPTY;
            end else begin
              state_next = cfd_pkg::ST_EMIT_RD;
            end
          end
        end
      end
      cfd_pkg::ST_EMIT_RD: begin
        state_next = cfd_pkg::ST_EMIT_WR;
      end
      cfd_pkg::ST_EMIT_WR: begin
        if (out_load) begin
          state_next = emit_last ? cfd_pkg::ST_HEAD1 : cfd_pkg::ST_EMIT_RD;
        end
      end
      cfd_pkg::ST_EMPTY: begin
        if (out_load) begin
          state_next = cfd_pkg::ST_HEAD1;
        end
      end
      default: state_next = cfd_pkg::ST_HEAD1;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready = 1'b0;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    out_load = 1'b0;
    unique case (state) inside
      cfd_pkg::ST_HEAD1, cfd_pkg::ST_HEAD2, cfd_pkg::ST_LEN, cfd_pkg::ST_FUNC: begin
        in_ready = 1'b1;
      end
      cfd_pkg::ST_DATA: begin
        in_ready = 1'b1;
        ram_we   = in_ch.valid && !len_bad;
      end
      cfd_pkg::ST_EMIT_RD: begin
        ram_re = 1'b1;
      end
      cfd_pkg::ST_EMIT_WR, cfd_pkg::ST_EMPTY: begin
        out_load = !out_valid || out_ch.ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= cfd_pkg::ST_HEAD1;
      header_first  <= '0;
      header_second <= '0;
      len_field     <= '0;
      frame_func    <= '0;
      collect_count <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        unique case (cfg.index)
          cfd_pkg::REG_HEADER_FIRST:  header_first <= cfg.data;
          cfd_pkg::REG_HEADER_SECOND: header_second <= cfg.data;
          default: header_first <= header_first;
        endcase
      end
      if (in_xfer && state == cfd_pkg::ST_LEN) begin
        len_field <= in_ch.rx_byte;
      end
      if (in_xfer && state == cfd_pkg::ST_FUNC) begin
        frame_func    <= in_ch.rx_byte;
        collect_count <= '0;
      end
      if (in_xfer && state == cfd_pkg::ST_DATA && !len_bad) begin
        collect_count <= count_inc;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // running checksum, replay pointer and output payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      unique case (state)
        cfd_pkg::ST_LEN: sum_acc <= in_ch.rx_byte;
        cfd_pkg::ST_FUNC: sum_acc <= sum_acc + in_ch.rx_byte;
        cfd_pkg::ST_DATA: begin
          if (!frame_done) begin
            sum_acc <= sum_acc + in_ch.rx_byte;
          end
          emit_idx <= '0;
          emit_end <= cfd_pkg::INDEX_W'(data_len - cfd_pkg::BYTE_W'(2));
        end
        default: sum_acc <= sum_acc;
      endcase
    end
    if (out_load) begin
      out_func <= frame_func;
      if (state == cfd_pkg::ST_EMIT_WR) begin
        out_payload <= ram_rdata;
        out_index   <= emit_idx;
        out_present <= 1'b1;
        out_last    <= emit_last;
        emit_idx    <= emit_idx + 1'b1;
      end else begin
        out_payload <= '0;
        out_index   <= '0;
        out_present <= 1'b0;
        out_last    <= 1'b1;
      end
    end
  end

  cfd_ram #(
    .WIDTH(cfd_pkg::BYTE_W),
    .DEPTH(cfd_pkg::PAYLOAD_BUFFER_BYTES)
  ) u_payload_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(collect_count[cfd_pkg::STORE_ADDR_W-1:0]),
    .wdata(in_ch.rx_byte),
    .re   (ram_re),
    .raddr(emit_idx[cfd_pkg::STORE_ADDR_W-1:0]),
    .rdata(ram_rdata)
  );

  assign in_ch.ready          = in_ready;
  assign cfg.ready            = 1'b1;
  assign out_ch.valid         = out_valid;
  assign out_ch.function_code = out_func;
  assign out_ch.payload_byte  = out_payload;
  assign out_ch.byte_index    = out_index;
  assign out_ch.byte_present  = out_present;
  assign out_ch.last          = out_last;

`ifndef SYNTHESIS
  a_emit_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == cfd_pkg::ST_EMIT_RD || state == cfd_pkg::ST_EMIT_WR) |-> emit_idx <= emit_end)
    else $error("replay pointer past end of frame");

  a_emit_continues: assert property (@(posedge clk) disable iff (rst)
    (out_load && state == cfd_pkg::ST_EMIT_WR && !emit_last) |=> state == cfd_pkg::ST_EMIT_RD)
    else $error("replay stopped before last payload byte");

  a_count_below_len: assert property (@(posedge clk) disable iff (rst)
    (state == cfd_pkg::ST_DATA && !len_bad) |-> {1'b0, collect_count} < data_len)
    else $error("collect count reached data length without frame end");

  a_ram_single_port_use: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("payload RAM written and read in one cycle");
`endif

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the checksummed frame deframer: scripted and random byte streams.
module testbench;

  typedef struct packed {
    logic [cfd_pkg::BYTE_W-1:0]  function_code;
    logic [cfd_pkg::BYTE_W-1:0]  payload_byte;
    logic [cfd_pkg::INDEX_W-1:0] byte_index;
    logic                        byte_present;
    logic                        last;
  } frame_out_t;

  typedef enum logic [1:0] {ROW_MODEL, ROW_NONE, ROW_ONE} row_kind_t;

  typedef struct packed {
    logic [cfd_pkg::BYTE_W-1:0] rx;
    row_kind_t                  kind;
    frame_out_t                 want;
  } stim_row_t;

  localparam frame_out_t NO_FRAME = '0;
  localparam int         PHASE_BYTES = 60;

  localparam stim_row_t RX_SCRIPT [22] = '{
    '{8'h00, ROW_MODEL, NO_FRAME},
    '{8'h00, ROW_MODEL, NO_FRAME},
    '{8'h05, ROW_MODEL, NO_FRAME},
    '{8'hFF, ROW_MODEL, NO_FRAME},
    '{8'h04, ROW_ONE,   '{8'hFF, 8'h00, 6'd0, 1'b0, 1'b1}},
    '{8'h00, ROW_MODEL, NO_FRAME},
    '{8'h00, ROW_MODEL, NO_FRAME},
    '{8'h04, ROW_MODEL, NO_FRAME},
    '{8'h12, ROW_MODEL, NO_FRAME},
    '{8'hAB, ROW_NONE,  NO_FRAME},
    '{8'h00, ROW_MODEL, NO_FRAME},
    '{8'h01, ROW_MODEL, NO_FRAME},
    '{8'h00, ROW_MODEL, NO_FRAME},
    '{8'h00, ROW_MODEL, NO_FRAME},
    '{8'h45, ROW_MODEL, NO_FRAME},
    '{8'h01, ROW_MODEL, NO_FRAME},
    '{8'h99, ROW_NONE,  NO_FRAME},
    '{8'h00, ROW_MODEL, NO_FRAME},
    '{8'h00, ROW_MODEL, NO_FRAME},
    '{8'h05, ROW_MODEL, NO_FRAME},
    '{8'h07, ROW_MODEL, NO_FRAME},
    '{8'h0D, ROW_NONE,  NO_FRAME}
  };

  logic clk = 1'b0;
  logic rst;
  logic calm = 1'b0;

  cfd_in_if  in_ch ();
  cfd_out_if out_ch ();
  cfd_cfg_if cfg ();

  checksummed_frame_deframer_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
  );

  always #6 clk = ~clk;

  logic [cfd_pkg::BYTE_W-1:0] hdr_first = '0;
  logic [cfd_pkg::BYTE_W-1:0] hdr_second = '0;
  cfd_pkg::phase_t            parse_ph = cfd_pkg::ST_HEAD1;
  logic [cfd_pkg::BYTE_W-1:0] len_field = '0;
  logic [cfd_pkg::BYTE_W-1:0] frame_func = '0;
  int                         fill = 0;
  logic [cfd_pkg::BYTE_W-1:0] rx_store [cfd_pkg::PAYLOAD_BUFFER_BYTES];

  frame_out_t step_out [$];
  frame_out_t payload_due [$];
  frame_out_t seen;
  frame_out_t due;
  int         mismatches = 0;
  int         rx_count = 0;

  function automatic void deframe_byte(input logic [cfd_pkg::BYTE_W-1:0] b);
    int dlen;
    int i;
    logic [cfd_pkg::BYTE_W-1:0] csum;
    step_out.delete();
    case (parse_ph)
      cfd_pkg::ST_HEAD1: if (b == hdr_first) parse_ph = cfd_pkg::ST_HEAD2;
      cfd_pkg::ST_HEAD2: parse_ph = (b == hdr_second) ? cfd_pkg::ST_LEN : cfd_pkg::ST_HEAD1;
      cfd_pkg::ST_LEN: begin
        len_field = b;
        parse_ph = cfd_pkg::ST_FUNC;
      end
      cfd_pkg::ST_FUNC: begin
        frame_func = b;
        fill = 0;
        parse_ph = cfd_pkg::ST_DATA;
      end
      cfd_pkg::ST_DATA: begin
        dlen = (len_field >= cfd_pkg::LEN_OVERHEAD) ?
               int'(len_field) - cfd_pkg::LEN_OVERHEAD : 0;
        if (dlen == 0 || dlen > cfd_pkg::PAYLOAD_BUFFER_BYTES) begin
          parse_ph = cfd_pkg::ST_HEAD1;
        end else begin
          rx_store[fill] = b;
          fill++;
          if (fill >= dlen) begin
            csum = hdr_first + hdr_second + len_field + frame_func;
            for (i = 0; i < dlen - 1; i++) csum += rx_store[i];
            if (csum == rx_store[dlen-1]) begin
              if (dlen == 1) begin
                step_out.push_back({frame_func, 8'h00, 6'd0, 1'b0, 1'b1});
              end else begin
                for (i = 0; i < dlen - 1; i++)
                  step_out.push_back({frame_func, rx_store[i], 6'(i), 1'b1, i == dlen - 2});
              end
            end
            parse_ph = cfd_pkg::ST_HEAD1;
          end
        end
      end
      default: parse_ph = cfd_pkg::ST_HEAD1;
    endcase
  endfunction

  task automatic send_byte(input logic [cfd_pkg::BYTE_W-1:0] b, input bit use_model = 1'b1);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    rx_count++;
    deframe_byte(b);
    if (use_model) foreach (step_out[i]) payload_due.push_back(step_out[i]);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (payload_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_headers(input logic [cfd_pkg::BYTE_W-1:0] h1,
                               input logic [cfd_pkg::BYTE_W-1:0] h2);
    cfg.valid <= 1'b1;
    cfg.index <= cfd_pkg::REG_HEADER_FIRST;
    cfg.data <= h1;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    hdr_first = h1;
    cfg.index <= cfd_pkg::REG_HEADER_SECOND;
    cfg.data <= h2;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    hdr_second = h2;
    cfg.valid <= 1'b0;
  endtask

  // keep: data bytes to send before cutting the frame short
  task automatic send_frame(input int dlen, input bit good, input int keep);
    logic [cfd_pkg::BYTE_W-1:0] func;
    logic [cfd_pkg::BYTE_W-1:0] csum;
    logic [cfd_pkg::BYTE_W-1:0] d;
    int i;
    func = 8'($urandom_range(0, 255));
    csum = hdr_first + hdr_second + 8'(dlen + cfd_pkg::LEN_OVERHEAD) + func;
    send_byte(hdr_first);
    send_byte(hdr_second);
    send_byte(8'(dlen + cfd_pkg::LEN_OVERHEAD));
    send_byte(func);
    for (i = 0; i < keep && i < dlen - 1; i++) begin
      d = 8'($urandom_range(0, 255));
      csum += d;
      send_byte(d);
    end
    if (keep >= dlen) send_byte(good ? csum : csum ^ 8'($urandom_range(1, 255)));
  endtask

  initial begin : receiver
    int stall;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 6) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      seen = {out_ch.function_code, out_ch.payload_byte, out_ch.byte_index,
              out_ch.byte_present, out_ch.last};
      if (payload_due.size() == 0) begin
        mismatches++;
        $display("%0t: expected no transfer, got func/data/idx/present/last %h/%h/%0d/%b/%b",
                 $time, seen.function_code, seen.payload_byte, seen.byte_index,
                 seen.byte_present, seen.last);
      end else begin
        due = payload_due.pop_front();
        if (seen !== due) begin
          mismatches++;
          $display("%0t: func/data/idx/present/last expected %h/%h/%0d/%b/%b, got %h/%h/%0d/%b/%b",
                   $time, due.function_code, due.payload_byte, due.byte_index,
                   due.byte_present, due.last, seen.function_code, seen.payload_byte,
                   seen.byte_index, seen.byte_present, seen.last);
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int p;
    int start;
    int pick;
    int dlen;
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.rx_byte <= '0;
    cfg.valid <= 1'b0;
    cfg.index <= cfd_pkg::REG_HEADER_FIRST;
    cfg.data <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (RX_SCRIPT[i]) begin
      send_byte(RX_SCRIPT[i].rx, RX_SCRIPT[i].kind == ROW_MODEL);
      if (RX_SCRIPT[i].kind == ROW_ONE) payload_due.push_back(RX_SCRIPT[i].want);
    end

    for (p = 0; p < 5; p++) begin
      while (parse_ph != cfd_pkg::ST_HEAD1) send_byte(hdr_second ^ 8'h01);
      settle();
      if (p == 4) calm = 1'b1;
      case (p)
        0: write_headers(8'hFF, 8'h00);
        1: write_headers(8'h00, 8'hFF);
        2: write_headers(8'h5A, 8'hA5);
        3: write_headers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        default: write_headers(8'hAA, 8'hAA);
      endcase
      start = rx_count;
      if (p == 0) begin
        send_frame(cfd_pkg::PAYLOAD_BUFFER_BYTES, 1'b1, cfd_pkg::PAYLOAD_BUFFER_BYTES);
      end
      while (rx_count - start < PHASE_BYTES) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          dlen = ($urandom_range(0, 19) == 0) ?
                 $urandom_range(56, cfd_pkg::PAYLOAD_BUFFER_BYTES) : $urandom_range(1, 8);
          send_frame(dlen, $urandom_range(0, 99) < 85, dlen);
          if (!calm && $urandom_range(0, 11) == 0) settle();
        end else if (pick < 80) begin
          repeat ($urandom_range(1, 3))
            send_byte($urandom_range(0, 1) ? hdr_first : 8'($urandom_range(0, 255)));
        end else if (pick < 88) begin
          send_byte(hdr_first);
          send_byte(hdr_second);
          send_byte($urandom_range(0, 1) ? 8'($urandom_range(0, cfd_pkg::LEN_OVERHEAD))
                                         : 8'($urandom_range(69, 255)));
          send_byte(8'($urandom_range(0, 255)));
          send_byte(8'($urandom_range(0, 255)));
        end else if (pick < 94) begin
          dlen = $urandom_range(2, 8);
          send_frame(dlen, 1'b1, $urandom_range(0, dlen - 1));
        end else begin
          send_byte(hdr_first);
          send_byte(hdr_first);
        end
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/cfd_pkg.sv
sv/cfd_if.sv
sv/cfd_ram.sv
sv/checksummed_frame_deframer_core.sv
tb/sv/testbench.sv
